// File: rtl/assert_macros.svh
// Assertion macros used by the scheduler core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CRS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CRS_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CRS_ASSERT(lbl, clk, rst_n, prop, msg)
`define CRS_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: rtl/crs_pkg.sv
// Types and constants of the command resend ring scheduler.
`timescale 1ns / 1ps
package crs_pkg;

	typedef enum logic [2:0] {
		FN_INSERT  = 3'd0,
		FN_REPLACE = 3'd1,
		FN_CLEAR   = 3'd2,
		FN_APPEND  = 3'd3,
		FN_DELETE  = 3'd4,
		FN_POLL    = 3'd5,
		FN_FINISH  = 3'd6
	} func_t;

	localparam logic [15:0] FIRST_IV_RESET = 16'd1000;

	typedef struct packed {
		logic [7:0]  code;
		logic [7:0]  count;
		logic [15:0] interval;
		logic        first;
	} slot_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  cmd_code;
		logic [7:0]  repeat_count;
		logic [15:0] send_interval;
		logic [31:0] now_time;
	} item_t;

	typedef struct packed {
		logic       send_now;
		logic [7:0] sent_cmd;
		logic [2:0] sent_slot;
		logic       dropped;
		logic [2:0] current_slot;
		logic [7:0] current_cmd;
	} result_t;

endpackage

// File: rtl/crs_ifs.sv
// Channel interfaces: command requests, results and configuration writes.
`timescale 1ns / 1ps
interface crs_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [7:0]  cmd_code;
	logic [7:0]  repeat_count;
	logic [15:0] send_interval;
	logic [31:0] now_time;
	modport source (output valid, func, cmd_code, repeat_count, send_interval, now_time,
		input ready);
	modport sink (input valid, func, cmd_code, repeat_count, send_interval, now_time,
		output ready);
endinterface

interface crs_rsp_if;
	logic       valid;
	logic       ready;
	logic       send_now;
	logic [7:0] sent_cmd;
	logic [2:0] sent_slot;
	logic       dropped;
	logic [2:0] current_slot;
	logic [7:0] current_cmd;
	modport source (output valid, send_now, sent_cmd, sent_slot, dropped, current_slot,
		current_cmd, input ready);
	modport sink (input valid, send_now, sent_cmd, sent_slot, dropped, current_slot,
		current_cmd, output ready);
endinterface

interface crs_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: rtl/crs_slot_store.sv
// Slot memory: one write and one registered read port, per-entry valid bits.
`timescale 1ns / 1ps
module crs_slot_store #(
	parameter int SLOTS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [$clog2(SLOTS)-1:0] wr_addr,
	input  crs_pkg::slot_t           wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(SLOTS)-1:0] rd_addr,
	output crs_pkg::slot_t           rd_data
);
	import crs_pkg::*;

	slot_t            mem [SLOTS];
	slot_t            rdata_q;
	logic [SLOTS-1:0] vld_q;
	logic             rvld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// never-written entries read as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rvld_q ? rdata_q : '0;

endmodule

// File: rtl/command_resend_ring_scheduler_core.sv
// Top level of the command resend ring scheduler.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Command resend ring scheduler.
// req (sink): one command operation per transfer (insert, replace, clear, append,
//   delete, poll, finish). rsp (source): exactly one result per request, in order.
// cfg (sink): write of first_interval, always ready; write it only while idle.
// The slot ring lives in a single-port-read synchronous memory; each request is
// a short read-modify-write sequence driven by the state machine below.
// Each request passes S_HEAD, then S_OUT, which registers its result into rsp; S_NEXT
//   lies between them when the slot after the pointer must be read (clear, matching
//   delete, finish, poll that frees a slot, append of code zero to an empty pointer
//   slot). Append searches in S_SRCH, one slot per memory read; req is ready only in idle.
// A finished result sits in the rsp register; the next request is taken while it
// waits, and that request's result is held back until rsp is free.
// Reset: all slots empty, pointer at slot 0, last send time 0, first_interval 1000.
//   Entries carry valid bits, so no clearing pass is needed after reset.
// Slot indices on rsp are the low three bits of the slot number.
module command_resend_ring_scheduler_core #(
	parameter int SLOTS = 8
) (
	input logic      clk,
	input logic      arst_n,
	crs_cfg_if.sink  cfg,
	crs_req_if.sink  req,
	crs_rsp_if.source rsp
);
	import crs_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
	localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_HEAD,   // head entry on the read port
		S_SRCH,   // append: walking the ring for an empty slot
		S_NEXT,   // entry after the pointer on the read port
		S_OUT     // hand result to rsp register
	} state_t;

	state_t        state_q;
	item_t         item_q;
	logic [IW-1:0] head_q;
	logic [IW-1:0] ptr_q;
	logic [CW-1:0] seen_q;
	logic          adv_all_q;
	logic [31:0]   last_send_q;
	logic [15:0]   first_iv_q;
	result_t       res_q;
	result_t       out_q;
	logic          out_valid_q;

	// memory port
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	slot_t         wr_data;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	slot_t         rd_data;

	logic          accept;
	logic [IW-1:0] h_next;
	logic [IW-1:0] h_prev;
	logic [IW-1:0] p_next;
	slot_t         ent_new;
	logic [15:0]   poll_wait;
	logic [31:0]   elapsed;
	logic          poll_go;
	logic [7:0]    cnt_dec;
	logic          poll_free;
	logic [IW+2:0] head_ext;
	logic [IW+2:0] out_slot_ext;

	crs_slot_store #(.SLOTS(SLOTS)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// ring neighbours, valid for any slot count
	assign h_next = (head_q == LAST) ? '0 : head_q + 1'b1;
	assign h_prev = (head_q == '0) ? LAST : head_q - 1'b1;
	assign p_next = (ptr_q == LAST) ? '0 : ptr_q + 1'b1;

	assign ent_new = '{code: item_q.cmd_code, count: item_q.repeat_count,
		interval: item_q.send_interval, first: 1'b1};

	// poll decision on the head entry, wrapping time difference
	assign poll_wait = rd_data.first ? first_iv_q : rd_data.interval;
	assign elapsed   = item_q.now_time - last_send_q;
	assign poll_go   = (rd_data.code != 8'd0) && (elapsed >= {16'd0, poll_wait});
	assign cnt_dec   = (rd_data.count != 8'd0) ? rd_data.count - 8'd1 : 8'd0;
	assign poll_free = (cnt_dec == 8'd0);

	assign head_ext     = {3'b000, head_q};
	assign out_slot_ext = head_ext;

	// memory requests
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = head_q;
		wr_data = '0;
		rd_en   = 1'b0;
		rd_addr = head_q;
		unique case (state_q)
			S_IDLE: begin
				rd_en = accept;
			end
			S_HEAD: begin
				case (item_q.func)
					FN_INSERT: begin
						wr_en   = 1'b1;
						wr_addr = (rd_data.code != 8'd0) ? h_prev : head_q;
						wr_data = ent_new;
					end
					FN_REPLACE: begin
						wr_en   = 1'b1;
						wr_data = ent_new;
					end
					FN_CLEAR: begin
						// clear keeps the first-send flag
						wr_en   = 1'b1;
						wr_data = '{code: 8'd0, count: 8'd0, interval: 16'd0,
							first: rd_data.first};
						rd_en   = 1'b1;
						rd_addr = h_next;
					end
					FN_DELETE: begin
						if (rd_data.code == item_q.cmd_code) begin
							wr_en   = 1'b1;
							wr_data = '{code: 8'd0, count: 8'd0, interval: 16'd0,
								first: rd_data.first};
							rd_en   = 1'b1;
							rd_addr = h_next;
						end
					end
					FN_APPEND: begin
						if (rd_data.code == 8'd0) begin
							wr_en   = 1'b1;
							wr_data = ent_new;
							rd_en   = (item_q.cmd_code == 8'd0);
						end else begin
							rd_en = 1'b1;
						end
						rd_addr = h_next;
					end
					FN_POLL: begin
						if (rd_data.code != 8'd0) begin
							wr_en   = 1'b1;
							wr_data = '{code: rd_data.code, count: rd_data.count,
								interval: rd_data.interval, first: 1'b0};
							if (poll_go) begin
								if (poll_free) begin
									wr_data = '0;
									rd_en   = 1'b1;
									rd_addr = h_next;
								end else begin
									wr_data.count = cnt_dec;
								end
							end
						end
					end
					FN_FINISH: begin
						wr_en   = 1'b1;
						wr_data = '0;
						rd_en   = 1'b1;
						rd_addr = h_next;
					end
					default: begin
					end
				endcase
			end
			S_SRCH: begin
				if (rd_data.code == 8'd0) begin
					wr_en   = 1'b1;
					wr_addr = ptr_q;
					wr_data = ent_new;
				end else if (seen_q + 1'b1 != SLOTS_C) begin
					rd_en   = 1'b1;
					rd_addr = p_next;
				end
			end
			S_NEXT, S_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer, state registers and rsp register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			item_q      <= '0;
			res_q       <= '0;
			out_q       <= '0;
			head_q      <= '0;
			last_send_q <= '0;
			first_iv_q  <= FIRST_IV_RESET;
			out_valid_q <= 1'b0;
			adv_all_q   <= 1'b0;
			ptr_q       <= '0;
			seen_q      <= '0;
		end else begin
			if (cfg.valid) begin
				first_iv_q <= cfg.data;
			end
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						item_q <= '{func: req.func, cmd_code: req.cmd_code,
							repeat_count: req.repeat_count,
							send_interval: req.send_interval, now_time: req.now_time};
						res_q  <= '0;
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					state_q <= S_OUT;
					res_q.current_cmd <= rd_data.code;
					case (item_q.func)
						FN_INSERT: begin
							head_q <= wr_addr;
							res_q.current_cmd <= item_q.cmd_code;
						end
						FN_REPLACE: begin
							res_q.current_cmd <= item_q.cmd_code;
						end
						FN_CLEAR: begin
							adv_all_q <= 1'b0;
							state_q   <= S_NEXT;
						end
						FN_DELETE: begin
							if (rd_data.code == item_q.cmd_code) begin
								adv_all_q <= 1'b0;
								state_q   <= S_NEXT;
							end
						end
						FN_APPEND: begin
							if (rd_data.code == 8'd0) begin
								res_q.current_cmd <= item_q.cmd_code;
								if (item_q.cmd_code == 8'd0) begin
									adv_all_q <= 1'b1;
									state_q   <= S_NEXT;
								end
							end else begin
								ptr_q   <= h_next;
								seen_q  <= CW'(1);
								state_q <= S_SRCH;
							end
						end
						FN_POLL: begin
							if (poll_go) begin
								res_q.send_now  <= 1'b1;
								res_q.sent_cmd  <= rd_data.code;
								res_q.sent_slot <= out_slot_ext[2:0];
								last_send_q     <= item_q.now_time;
								if (poll_free) begin
									adv_all_q <= 1'b1;
									state_q   <= S_NEXT;
								end
							end
						end
						FN_FINISH: begin
							adv_all_q <= 1'b1;
							state_q   <= S_NEXT;
						end
						default: begin
						end
					endcase
				end
				S_SRCH: begin
					// pointer slot is occupied here, so it stays put
					if (rd_data.code == 8'd0) begin
						state_q <= S_OUT;
					end else if (seen_q + 1'b1 == SLOTS_C) begin
						res_q.dropped <= 1'b1;
						state_q       <= S_OUT;
					end else begin
						ptr_q  <= p_next;
						seen_q <= seen_q + 1'b1;
					end
				end
				S_NEXT: begin
					if (adv_all_q || rd_data.code != 8'd0) begin
						head_q            <= h_next;
						res_q.current_cmd <= rd_data.code;
					end else begin
						res_q.current_cmd <= 8'd0;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || rsp.ready) begin
						out_q <= '{send_now: res_q.send_now, sent_cmd: res_q.sent_cmd,
							sent_slot: res_q.sent_slot, dropped: res_q.dropped,
							current_slot: head_ext[2:0], current_cmd: res_q.current_cmd};
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.send_now     = out_q.send_now;
	assign rsp.sent_cmd     = out_q.sent_cmd;
	assign rsp.sent_slot    = out_q.sent_slot;
	assign rsp.dropped      = out_q.dropped;
	assign rsp.current_slot = out_q.current_slot;
	assign rsp.current_cmd  = out_q.current_cmd;

	`CRS_NEVER(a_head_range, clk, arst_n, head_q > LAST, "pointer outside the ring")
	`CRS_ASSERT(a_send_code, clk, arst_n, rsp.valid && rsp.send_now |-> rsp.sent_cmd != 8'd0, "send of an empty slot")
	`CRS_ASSERT(a_idle_no_wr, clk, arst_n, state_q == S_IDLE |-> !wr_en, "slot write while idle")
	`CRS_ASSERT(a_out_hold, clk, arst_n, state_q == S_OUT && out_valid_q && !rsp.ready |=> state_q == S_OUT, "result overwrote a stalled rsp")

endmodule

// File: tb/command_resend_ring_scheduler_core_tb.sv
// Self-checking testbench for the command resend ring scheduler core.
`timescale 1ns / 1ps
module command_resend_ring_scheduler_core_tb;
	import crs_pkg::*;

	localparam int        SLOT_COUNT = 8;
	// func value with no operation behind it: state untouched, pointer reported
	localparam logic [2:0] FN_UNUSED = 3'd7;
	localparam int        PHASES     = 6;
	localparam int        PHASE_LEN  = 105;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	crs_req_if req_ch();
	crs_rsp_if rsp_ch();
	crs_cfg_if cfg_ch();

	command_resend_ring_scheduler_core #(
		.SLOTS(SLOT_COUNT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the slot ring. Every request that is transferred is applied
	// here straight away and the result it must produce is queued; results from
	// the block are matched in order against that queue.
	class resend_ring_tracker;
		bit [7:0]  code [SLOT_COUNT];
		bit [7:0]  count [SLOT_COUNT];
		bit [15:0] ivl [SLOT_COUNT];
		bit        fresh [SLOT_COUNT];
		bit [2:0]  head;
		bit [31:0] last_sent_at;
		bit [15:0] first_wait;
		result_t   awaited [$];
		int        errors;
		int        sends;
		int        drops;
		int        checked;

		function new();
			for (int i = 0; i < SLOT_COUNT; i++) begin
				code[i]  = '0;
				count[i] = '0;
				ivl[i]   = '0;
				fresh[i] = 1'b0;
			end
			head         = '0;
			last_sent_at = '0;
			first_wait   = FIRST_IV_RESET;
			errors       = 0;
			sends        = 0;
			drops        = 0;
			checked      = 0;
		endfunction

		function void store(bit [2:0] s, item_t it);
			code[s]  = it.cmd_code;
			count[s] = it.repeat_count;
			ivl[s]   = it.send_interval;
			fresh[s] = 1'b1;
		endfunction

		// clear/delete: first-send flag survives, pointer moves only onto a live slot
		function void clear_head();
			code[head]  = '0;
			count[head] = '0;
			ivl[head]   = '0;
			if (code[head + 3'd1] != 8'd0)
				head = head + 3'd1;
		endfunction

		// send-out or finish: slot wiped completely, pointer always moves on
		function void free_head();
			code[head]  = '0;
			count[head] = '0;
			ivl[head]   = '0;
			fresh[head] = 1'b0;
			head        = head + 3'd1;
		endfunction

		function void note_request(item_t it);
			result_t   r;
			bit [2:0]  h;
			bit [2:0]  p;
			bit        found;
			bit [31:0] hold;
			r = '0;
			h = head;
			case (it.func)
				FN_INSERT: begin
					if (code[h] != 8'd0)
						head = h - 3'd1;
					store(head, it);
				end
				FN_REPLACE: store(h, it);
				FN_CLEAR: clear_head();
				FN_APPEND: begin
					found = 1'b0;
					p = h;
					for (int i = 0; i < SLOT_COUNT && !found; i++) begin
						if (code[p] == 8'd0)
							found = 1'b1;
						else
							p = p + 3'd1;
					end
					if (!found) begin
						r.dropped = 1'b1;
						drops++;
					end else begin
						store(p, it);
						// a zero code written at the pointer leaves it empty
						if (code[h] == 8'd0)
							head = h + 3'd1;
					end
				end
				FN_DELETE: begin
					if (code[h] == it.cmd_code)
						clear_head();
				end
				FN_POLL: begin
					if (code[h] != 8'd0) begin
						hold = fresh[h] ? {16'd0, first_wait} : {16'd0, ivl[h]};
						fresh[h] = 1'b0;
						if (it.now_time - last_sent_at >= hold) begin
							r.send_now  = 1'b1;
							r.sent_cmd  = code[h];
							r.sent_slot = h;
							if (count[h] != 8'd0)
								count[h] = count[h] - 8'd1;
							if (count[h] == 8'd0)
								free_head();
							last_sent_at = it.now_time;
							sends++;
						end
					end
				end
				FN_FINISH: begin
					count[h] = '0;
					free_head();
				end
				default: ;
			endcase
			r.current_slot = head;
			r.current_cmd  = code[head];
			awaited.push_back(r);
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			$display("%0t: mismatch on %s: got 0x%0h, wanted 0x%0h", $time, what, got, want);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				report_mismatch("result with nothing outstanding", 32'(got), '0);
				return;
			end
			want = awaited.pop_front();
			checked++;
			if (got.send_now !== want.send_now)
				report_mismatch("send_now", 32'(got.send_now), 32'(want.send_now));
			if (got.sent_cmd !== want.sent_cmd)
				report_mismatch("sent_cmd", 32'(got.sent_cmd), 32'(want.sent_cmd));
			if (got.sent_slot !== want.sent_slot)
				report_mismatch("sent_slot", 32'(got.sent_slot), 32'(want.sent_slot));
			if (got.dropped !== want.dropped)
				report_mismatch("dropped", 32'(got.dropped), 32'(want.dropped));
			if (got.current_slot !== want.current_slot)
				report_mismatch("current_slot", 32'(got.current_slot),
					32'(want.current_slot));
			if (got.current_cmd !== want.current_cmd)
				report_mismatch("current_cmd", 32'(got.current_cmd), 32'(want.current_cmd));
		endtask
	endclass

	resend_ring_tracker tracker;
	bit        quiet_stretch = 1'b0;   // when set neither side idles
	logic [31:0] wall_clock = '0;     // free-running time handed to polls
	int        issued = 0;
	int        settings_used = 1;     // reset value counts as the first

	// Idle length: half the time none, mostly short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99, 0);
		if (quiet_stretch || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(30, 5);
	endfunction

	function automatic item_t make_item(logic [2:0] f, logic [7:0] c, logic [7:0] n,
		logic [15:0] v, logic [31:0] t);
		return '{func: f, cmd_code: c, repeat_count: n, send_interval: v, now_time: t};
	endfunction

	// One request transfer. Valid is only dropped when a gap is taken, so
	// back-to-back requests keep it high across the edge.
	task automatic issue(input item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.func          <= it.func;
		req_ch.cmd_code      <= it.cmd_code;
		req_ch.repeat_count  <= it.repeat_count;
		req_ch.send_interval <= it.send_interval;
		req_ch.now_time      <= it.now_time;
		do @(posedge clk); while (!req_ch.ready);
		tracker.note_request(it);
		issued++;
	endtask

	// Hold the request side until every outstanding result is back, then let
	// a few more cycles pass to catch any stray transfer.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (tracker.awaited.size() != 0)
			@(posedge clk);
		repeat (SLOT_COUNT + 4) @(posedge clk);
	endtask

	// first_interval is only written with the block idle
	task automatic write_first_interval(input logic [15:0] v);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		tracker.first_wait = v;
		settings_used++;
	endtask

	// Mostly polls and appends against a steadily advancing clock, so commands
	// really get sent, counted down and retired; the rest mixes in the other
	// operations, odd field values and occasional jumps of the time base.
	function automatic item_t random_item();
		int          pick;
		int          r;
		logic [2:0]  f;
		logic [7:0]  c;
		logic [7:0]  n;
		logic [15:0] v;
		logic [31:0] t;
		r = $urandom_range(99, 0);
		if (r < 70)
			wall_clock = wall_clock + $urandom_range(60, 0);
		else if (r < 90)
			wall_clock = wall_clock + $urandom_range(2000, 0);
		else if (r < 97)
			wall_clock = wall_clock + $urandom_range(70000, 0);
		else
			wall_clock = $urandom();

		r = $urandom_range(99, 0);
		if (r < 6)
			c = 8'd0;
		else if (r < 12)
			c = 8'hFF;
		else
			c = 8'($urandom_range(254, 1));

		r = $urandom_range(99, 0);
		if (r < 45)
			n = 8'($urandom_range(3, 1));
		else if (r < 58)
			n = 8'd0;
		else if (r < 62)
			n = 8'hFF;
		else
			n = 8'($urandom_range(20, 4));

		r = $urandom_range(99, 0);
		if (r < 70)
			v = 16'($urandom_range(40, 0));
		else if (r < 80)
			v = 16'd0;
		else if (r < 90)
			v = 16'hFFFF;
		else
			v = 16'($urandom_range(65535, 0));

		// time field is ignored outside polls, so fill it with noise there
		t = $urandom();
		pick = $urandom_range(99, 0);
		if (pick < 40) begin
			f = FN_POLL;
			t = wall_clock;
		end else if (pick < 58)
			f = FN_APPEND;
		else if (pick < 68)
			f = FN_INSERT;
		else if (pick < 74)
			f = FN_REPLACE;
		else if (pick < 79)
			f = FN_CLEAR;
		else if (pick < 87) begin
			f = FN_DELETE;
			// a delete mostly names what is at the pointer, else it never bites
			if ($urandom_range(9, 0) < 7)
				c = tracker.code[tracker.head];
		end else if (pick < 93)
			f = FN_FINISH;
		else
			f = FN_UNUSED;
		return make_item(f, c, n, v, t);
	endfunction

	// Result side: check every transfer, stall ready at random.
	initial begin
		int      stall_left;
		result_t seen;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen = {rsp_ch.send_now, rsp_ch.sent_cmd, rsp_ch.sent_slot, rsp_ch.dropped,
					rsp_ch.current_slot, rsp_ch.current_cmd};
				tracker.check_result(seen);
			end
			if (!arst_n)
				rsp_ch.ready <= 1'b0;
			else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (quiet_stretch)
				rsp_ch.ready <= 1'b1;
			else begin
				stall_left = pick_gap();
				rsp_ch.ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// Request side and run control.
	initial begin
		logic [15:0] phase_wait [PHASES];
		tracker = new();
		req_ch.valid         <= 1'b0;
		req_ch.func          <= FN_POLL;
		req_ch.cmd_code      <= '0;
		req_ch.repeat_count  <= '0;
		req_ch.send_interval <= '0;
		req_ch.now_time      <= '0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.data          <= '0;
		phase_wait = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(65535, 0)), 16'd50,
			FIRST_IV_RESET};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Opening sequence, under the reset first_interval.
		issue(make_item(FN_POLL, 8'd0, 8'd0, 16'd0, 32'd0));              // poll on empty ring
		issue(make_item(FN_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF));
		issue(make_item(FN_APPEND, 8'hFF, 8'd0, 16'hFFFF, 32'd0));        // zero repeat count
		issue(make_item(FN_INSERT, 8'h01, 8'd1, 16'd0, 32'd0));           // pointer steps back
		issue(make_item(FN_POLL, 8'd0, 8'd0, 16'd0, 32'd0));              // first wait not over
		issue(make_item(FN_POLL, 8'd0, 8'd0, 16'd0, 32'd0));              // flag gone: interval 0
		issue(make_item(FN_POLL, 8'd0, 8'd0, 16'd0, 32'hFFFF_FFFF));      // send with count zero
		issue(make_item(FN_REPLACE, 8'h80, 8'd3, 16'd10, 32'd0));
		issue(make_item(FN_DELETE, 8'h7F, 8'd0, 16'd0, 32'd0));           // code does not match
		issue(make_item(FN_DELETE, 8'h80, 8'd0, 16'd0, 32'd0));           // match, next empty
		issue(make_item(FN_CLEAR, 8'd0, 8'd0, 16'd0, 32'd0));             // clear an empty slot
		issue(make_item(FN_FINISH, 8'd0, 8'd0, 16'd0, 32'd0));            // finish on empty slot
		issue(make_item(FN_APPEND, 8'd0, 8'd5, 16'd7, 32'd0));            // append of code zero
		for (int i = 0; i < SLOT_COUNT; i++)
			issue(make_item(FN_APPEND, 8'h11 + 8'(i), 8'(i + 1), 16'(3 * i), 32'd0));
		issue(make_item(FN_APPEND, 8'h99, 8'd1, 16'd1, 32'd0));           // ring full: dropped
		issue(make_item(FN_INSERT, 8'h55, 8'd2, 16'd3, 32'd0));           // overwrites occupied
		issue(make_item(FN_POLL, 8'd0, 8'd0, 16'd0, 32'd5));              // wraps past last send
		issue(make_item(FN_POLL, 8'd0, 8'd0, 16'd0, 32'h0000_1000));
		issue(make_item(FN_FINISH, 8'd0, 8'd0, 16'd0, 32'd0));
		issue(make_item(FN_CLEAR, 8'd0, 8'd0, 16'd0, 32'd0));             // next slot occupied
		wall_clock = 32'h0000_2000;

		// Random phases, each under its own first_interval; extremes first.
		for (int ph = 0; ph < PHASES; ph++) begin
			write_first_interval(phase_wait[ph]);
			if (ph == 3)
				wall_clock = 32'hFFFF_F000;   // let the time base wrap in this phase
			for (int k = 0; k < PHASE_LEN; k++) begin
				quiet_stretch = (k >= 30 && k < 55);
				if (k == 70)
					drain();   // hold requests until every result is in
				issue(random_item());
			end
			quiet_stretch = 1'b0;
		end

		drain();
		$display("Run covered %0d requests under %0d first-interval settings, 0 and 65535 among them;",
			issued, settings_used);
		$display("%0d sends, %0d dropped appends, %0d results checked.",
			tracker.sends, tracker.drops, tracker.checked);
		if (tracker.errors == 0)
			$display("PASS command_resend_ring_scheduler_core");
		else
			$display("FAIL command_resend_ring_scheduler_core");
		$finish;
	end

	// Watchdog: far beyond the slowest legitimate run.
	initial begin
		#10ms;
		$display("FAIL command_resend_ring_scheduler_core");
		$finish;
	end

endmodule
